### rtl/core/pce_pkg.sv
// Shared constants, types and sequencer states of the Pearson correlation engine.
package pce_pkg;

	localparam int MAX_LENGTH = 4096;
	localparam int CNT_W      = $clog2(MAX_LENGTH + 1);
	localparam int SX_W       = 20;
	localparam int SY_W       = 28;
	localparam int SXX_W      = 27;
	localparam int SYY_W      = 43;
	localparam int SXY_W      = 36;
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [SX_W-1:0]  sx;
		logic [SY_W-1:0]  sy;
		logic [SXX_W-1:0] sxx;
		logic [SYY_W-1:0] syy;
		logic [SXY_W-1:0] sxy;
	} sums_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_MUL  = 7'b0000010,
		ST_SUB  = 7'b0000100,
		ST_SQR  = 7'b0001000,
		ST_DIV  = 7'b0010000,
		ST_ROOT = 7'b0100000,
		ST_OUT  = 7'b1000000
	} back_state_t;

endpackage

### rtl/core/pearson_correlation_engine_top.sv
// Top level of the streaming Pearson correlation engine.
//
//   channel  direction  handshake     payload
//   pairs    in         push / full   x_sample, y_sample, last_pair
//   results  out        pop / empty   correlation, degenerate
//
// One pair is accepted per cycle while the hand-off queue has room.
// After its last pair, a vector's result is formed by 56 serial multiply
// steps, 33 divide steps and 17 root steps; degenerate ones skip those.
// The two-entry queue lets accumulation of the next vector proceed meanwhile.
// full rises only when two finished vectors wait; reset clears the front sums.
module pearson_correlation_engine_top import pce_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [7:0]  x_sample,
	input  logic signed [15:0] y_sample,
	input  logic               last_pair,
	input  logic               pop,
	output logic               empty,
	output logic signed [15:0] correlation,
	output logic               degenerate
);

	logic  wr_en;
	sums_t wr_data;
	logic  rd_en;
	sums_t rd_data;
	logic  rd_valid;

	pce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.x_sample  (x_sample),
		.y_sample  (y_sample),
		.last_pair (last_pair),
		.q_full    (full),
		.wr_en     (wr_en),
		.wr_data   (wr_data)
	);

	pce_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_data  (wr_data),
		.rd_en    (rd_en),
		.rd_data  (rd_data),
		.rd_valid (rd_valid),
		.full     (full)
	);

	pce_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (rd_valid),
		.q_data      (rd_data),
		.q_pop       (rd_en),
		.pop         (pop),
		.empty       (empty),
		.correlation (correlation),
		.degenerate  (degenerate)
	);

endmodule

### rtl/core/pce_front.sv
// Front end: accepts sample pairs, keeps the running sums, hands off a vector on its last pair.
module pce_front import pce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic signed [7:0] x_sample,
	input  logic signed [15:0] y_sample,
	input  logic              last_pair,
	input  logic              q_full,
	output logic              wr_en,
	output sums_t             wr_data
);

	sums_t             sum_q;
	sums_t             nxt;
	logic              accept;
	logic              acc_en;
	logic signed [15:0] xx;
	logic signed [31:0] yy;
	logic signed [23:0] xy;

	assign accept = push && !q_full;
	assign acc_en = sum_q.n < CNT_W'(MAX_LENGTH);
	assign xx     = x_sample * x_sample;
	assign yy     = y_sample * y_sample;
	assign xy     = x_sample * y_sample;

	always_comb begin
		nxt.n   = sum_q.n + CNT_W'(1);
		nxt.sx  = sum_q.sx + {{(SX_W-8){x_sample[7]}}, x_sample};
		nxt.sy  = sum_q.sy + {{(SY_W-16){y_sample[15]}}, y_sample};
		nxt.sxx = sum_q.sxx + {{(SXX_W-15){1'b0}}, xx[14:0]};
		nxt.syy = sum_q.syy + {{(SYY_W-31){1'b0}}, yy[30:0]};
		nxt.sxy = sum_q.sxy + {{(SXY_W-24){xy[23]}}, xy};
	end

	assign wr_en   = accept && last_pair;
	assign wr_data = acc_en ? nxt : sum_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (accept) begin
			if (last_pair) begin
				sum_q <= '0;
			end else if (acc_en) begin
				sum_q <= nxt;
			end
		end
	end

endmodule

### rtl/core/pce_queue.sv
// Two-entry queue of finished sum sets between front and back.
module pce_queue import pce_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_en,
	input  sums_t wr_data,
	input  logic  rd_en,
	output sums_t rd_data,
	output logic  rd_valid,
	output logic  full
);

	sums_t               mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]  wp_q;
	logic [Q_PTR_W-1:0]  rp_q;
	logic [Q_CNT_W-1:0]  cnt_q;
	logic                do_wr;
	logic                do_rd;

	assign full     = cnt_q == Q_CNT_W'(Q_DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_data  = mem_q[rp_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= wp_q + Q_PTR_W'(1);
			end
			if (do_rd) begin
				rp_q <= rp_q + Q_PTR_W'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/core/pce_back.sv
// Back end: sequenced products, serial multiplies, restoring divide, integer root, result register.
module pce_back import pce_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  sums_t              q_data,
	output logic               q_pop,
	input  logic               pop,
	output logic               empty,
	output logic signed [15:0] correlation,
	output logic               degenerate
);

	back_state_t         st_q;
	sums_t               src_q;
	logic signed [49:0]  nsxy_q;
	logic signed [47:0]  sxsy_q;
	logic [39:0]         nsxx_q;
	logic [39:0]         sx2_q;
	logic [55:0]         nsyy_q;
	logic [55:0]         sy2_q;
	logic [96:0]         ma_q;
	logic [55:0]         mb_q;
	logic [96:0]         na_q;
	logic [49:0]         nb_q;
	logic [96:0]         pacc_q;
	logic [96:0]         racc_q;
	logic [96:0]         rem_q;
	logic [32:0]         quot_q;
	logic [16:0]         s_q;
	logic [16:0]         rb_q;
	logic [5:0]          cnt_q;
	logic                neg_q;
	logic                deg_q;
	logic                ov_q;
	logic signed [15:0]  corr_q;
	logic                odeg_q;

	logic signed [50:0]  num;
	logic [39:0]         vx;
	logic [55:0]         vy;
	logic [50:0]         num_abs;
	logic [97:0]         cand;
	logic                ge;
	logic [16:0]         trial;
	logic [33:0]         trial_sq;
	logic [17:0]         s_inc;
	logic [16:0]         k;
	logic [15:0]         res;

	assign num      = {nsxy_q[49], nsxy_q} - {{3{sxsy_q[47]}}, sxsy_q};
	assign vx       = nsxx_q - sx2_q;
	assign vy       = nsyy_q - sy2_q;
	assign num_abs  = num[50] ? 51'(-num) : num;
	assign cand     = (cnt_q == '0) ? {1'b0, racc_q} : {rem_q, 1'b0};
	assign ge       = cand >= {1'b0, pacc_q};
	assign trial    = s_q | rb_q;
	assign trial_sq = trial * trial;
	assign s_inc    = {1'b0, s_q} + 18'd1;
	assign k        = s_inc[17:1];

	always_comb begin
		if (neg_q) begin
			res = 16'(-k);
		end else if (k > 17'd32767) begin
			res = 16'h7fff;
		end else begin
			res = k[15:0];
		end
	end

	assign q_pop       = (st_q == ST_IDLE) && q_valid;
	assign empty       = !ov_q;
	assign correlation = corr_q;
	assign degenerate  = odeg_q;

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				src_q <= q_data;
			end
			ST_MUL: begin
				nsxy_q <= $signed({1'b0, src_q.n}) * $signed(src_q.sxy);
				sxsy_q <= $signed(src_q.sx) * $signed(src_q.sy);
				nsxx_q <= 40'(src_q.n * src_q.sxx);
				sx2_q  <= 40'($signed(src_q.sx) * $signed(src_q.sx));
				nsyy_q <= 56'(src_q.n * src_q.syy);
				sy2_q  <= 56'($signed(src_q.sy) * $signed(src_q.sy));
			end
			ST_SUB: begin
				ma_q   <= {57'd0, vx};
				mb_q   <= vy;
				na_q   <= {47'd0, num_abs[49:0]};
				nb_q   <= num_abs[49:0];
				pacc_q <= '0;
				racc_q <= '0;
				rb_q   <= 17'h10000;
				s_q    <= '0;
				neg_q  <= num[50];
				deg_q  <= (vx == '0) || (vy == '0);
			end
			ST_SQR: begin
				if (mb_q[0]) begin
					pacc_q <= pacc_q + ma_q;
				end
				if (nb_q[0]) begin
					racc_q <= racc_q + na_q;
				end
				ma_q <= {ma_q[95:0], 1'b0};
				mb_q <= {1'b0, mb_q[55:1]};
				na_q <= {na_q[95:0], 1'b0};
				nb_q <= {1'b0, nb_q[49:1]};
			end
			ST_DIV: begin
				rem_q  <= ge ? 97'(cand - {1'b0, pacc_q}) : cand[96:0];
				quot_q <= {quot_q[31:0], ge};
			end
			ST_ROOT: begin
				if (trial_sq <= {1'b0, quot_q}) begin
					s_q <= trial;
				end
				rb_q <= {1'b0, rb_q[16:1]};
			end
			default: begin
			end
		endcase
		if (st_q == ST_OUT && !ov_q) begin
			corr_q <= deg_q ? 16'sd0 : $signed(res);
			odeg_q <= deg_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			if (ov_q && pop) begin
				ov_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						st_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					st_q <= ST_SUB;
				end
				ST_SUB: begin
					cnt_q <= '0;
					st_q  <= ((vx == '0) || (vy == '0)) ? ST_OUT : ST_SQR;
				end
				ST_SQR: begin
					if (cnt_q == 6'd55) begin
						cnt_q <= '0;
						st_q  <= ST_DIV;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_DIV: begin
					if (cnt_q == 6'd32) begin
						cnt_q <= '0;
						st_q  <= ST_ROOT;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_ROOT: begin
					if (rb_q[0]) begin
						st_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!ov_q) begin
						ov_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/pce_checker.sv
// Port-level checks of the correlation engine and their binding to the top level.
module pce_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input logic signed [7:0]  x_sample,
	input logic signed [15:0] y_sample,
	input logic               last_pair,
	input logic               pop,
	input logic               empty,
	input logic signed [15:0] correlation,
	input logic               degenerate
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty)
		else $error("result dropped while stalled");

	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && degenerate |-> correlation == 16'sd0)
		else $error("degenerate result not zero");

	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && last_pair))
		else $error("queue filled without a last item");

	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty |-> !$isunknown({correlation, degenerate})) and
		(push && !full |-> !$isunknown({x_sample, y_sample, last_pair})))
		else $error("unknown value on an accepted item");

endmodule

bind pearson_correlation_engine_top pce_checker u_pce_checker (.*);
